[rtl/base64_stream_decoder_assert.svh]
// base64_stream_decoder_assert.svh: assertion macros for the base64 decoder checks
// depends on a clock named clk and a synchronous reset named rst in the using scope
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// property checked only outside reset
`define B64D_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("base64 decoder check failed");

// property checked during reset as well
`define B64D_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("base64 decoder reset check failed");

`endif

[rtl/b64d_pkg.sv]
// b64d_pkg: payload types, codes and the character table of the base64 decoder
// no dependencies
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic ACTION_DATA = 1'b0;
  localparam logic ACTION_END  = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // input request
  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } text_t;

  // one result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       status;
    logic       last;
  } result_t;

  // up to three results caused by one request
  typedef struct packed {
    logic [1:0] count;
    logic       kind;
    logic       status;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // decoded character class
  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] sextet;
  } sym_t;

  function automatic sym_t map_char(input logic [7:0] c);
    sym_t s;
    s = '{bad: 1'b0, pad: 1'b0, sextet: 6'd0};
    if (c >= 8'h41 && c <= 8'h5a) begin
      s.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s.sextet = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.sextet = 6'(c + 8'd4);
    end else if (c == 8'h2b) begin
      s.sextet = 6'd62;
    end else if (c == 8'h2f) begin
      s.sextet = 6'd63;
    end else if (c == 8'h3d) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

[rtl/b64d_fifo.sv]
// b64d_fifo: short command queue between the decoder front and the output stage
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  b64d_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output b64d_pkg::cmd_t          head,
  output b64d_pkg::fifo_status_t  status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b64d_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  logic do_push;
  logic do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/b64d_front.sv]
// b64d_front: accepts text requests, tracks group state and builds result commands
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  b64d_pkg::text_t  text,
  output logic             push,
  output b64d_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    COLLECT,
    DOOMED,
    AFTER_PAD,
    PASS
  } mode_t;

  mode_t         mode;
  mode_t         mode_next;
  logic [1:0]    slot_count;
  logic [1:0]    slot_count_next;
  logic [17:0]   held;
  logic [17:0]   held_next;
  logic          third_pad;
  logic          third_pad_next;

  b64d_pkg::sym_t sym;
  logic           space;
  logic [5:0]     s0, s1, s2, v;

  assign s0 = held[5:0];
  assign s1 = held[11:6];
  assign s2 = held[17:12];

  always_comb begin
    mode_next       = mode;
    slot_count_next = slot_count;
    held_next       = held;
    third_pad_next  = third_pad;
    cmd             = '0;
    sym             = b64d_pkg::map_char(text.in_byte);
    space           = b64d_pkg::is_space(text.in_byte);
    v               = sym.pad ? 6'd0 : sym.sextet;
    cmd.kind        = b64d_pkg::KIND_DATA;
    cmd.data0       = text.in_byte;
    if (accept) begin
      if (text.action == b64d_pkg::ACTION_END) begin
        cmd.count       = 2'd1;
        cmd.kind        = b64d_pkg::KIND_END;
        cmd.status      = (mode == PASS) || (slot_count != 2'd0);
        cmd.data0       = 8'd0;
        mode_next       = COLLECT;
        slot_count_next = 2'd0;
        held_next       = '0;
        third_pad_next  = 1'b0;
      end else if (mode == PASS) begin
        cmd.count = 2'd1;
      end else if (mode == AFTER_PAD) begin
        if (!space) begin
          cmd.count = 2'd1;
          mode_next = PASS;
        end
      end else if (!space) begin
        if (sym.bad) begin
          cmd.count = 2'd1;
          mode_next = PASS;
        end else if (slot_count != 2'd3) begin
          // store the sextet, padding counts as zero
          if (sym.pad) begin
            if (slot_count < 2'd2) begin
              mode_next = DOOMED;
            end else begin
              third_pad_next = 1'b1;
            end
          end
          case (slot_count)
            2'd0:    held_next[5:0]   = v;
            2'd1:    held_next[11:6]  = v;
            default: held_next[17:12] = v;
          endcase
          slot_count_next = slot_count + 2'd1;
        end else begin
          slot_count_next = 2'd0;
          held_next       = '0;
          third_pad_next  = 1'b0;
          if (mode == DOOMED) begin
            cmd.count = 2'd1;
            mode_next = PASS;
          end else begin
            cmd.data0 = {s0, s1[5:4]};
            if (third_pad) begin
              if (sym.pad) begin
                cmd.count = 2'd1;
                mode_next = AFTER_PAD;
              end else begin
                // padding in the third slot only: raw fourth byte follows
                cmd.count = 2'd2;
                cmd.data1 = text.in_byte;
                mode_next = PASS;
              end
            end else begin
              cmd.data1 = {s1[3:0], s2[5:2]};
              if (sym.pad) begin
                cmd.count = 2'd2;
                mode_next = AFTER_PAD;
              end else begin
                cmd.count = 2'd3;
                cmd.data2 = {s2[1:0], v};
              end
            end
          end
        end
      end
    end
  end

  assign push = accept && (cmd.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= COLLECT;
      slot_count <= 2'd0;
      held       <= '0;
      third_pad  <= 1'b0;
    end else begin
      mode       <= mode_next;
      slot_count <= slot_count_next;
      held       <= held_next;
      third_pad  <= third_pad_next;
    end
  end

endmodule

[rtl/b64d_back.sv]
// b64d_back: output stage that drains one queued result per unstalled cycle
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_back (
  input  logic                    clk,
  input  logic                    rst,
  input  b64d_pkg::cmd_t          head,
  input  b64d_pkg::fifo_status_t  fifo_status,
  output logic                    pop,
  output logic                    result_valid,
  input  logic                    result_stall,
  output b64d_pkg::result_t       result
);

  logic [1:0] idx;
  logic       load;
  logic       take;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = !result_valid || !result_stall;
  assign take    = load && !fifo_status.empty;
  assign is_last = (idx == head.count - 2'd1);
  assign pop     = take && is_last;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.data0;
      2'd1:    sel_byte = head.data1;
      default: sel_byte = head.data2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.out_byte <= sel_byte;
      result.kind     <= head.kind;
      result.status   <= head.status;
      result.last     <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= 2'd0;
    end else if (load) begin
      result_valid <= !fifo_status.empty;
      if (take) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

[rtl/base64_stream_decoder.sv]
// base64_stream_decoder: top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back
`timescale 1ns / 1ps

// Streaming base64 decoder. One text request (a raw byte, or an end-of-stream
// mark) is taken per cycle whenever text_stall is low. Whitespace is dropped,
// groups of four alphabet characters become one to three bytes, and after a
// character outside the alphabet, or any non-whitespace after correct padding,
// the byte and everything after it pass through raw; after misplaced padding,
// raw output starts at the fourth character of its group at the latest. An end
// request yields one result of kind end whose status is 1 for a malformed or
// truncated stream, and returns the block to its reset state. The front
// classifies each byte in the cycle it is accepted and puts a command of up to
// three results into a QUEUE_DEPTH-entry queue; the output register drains one
// result per cycle while result_stall is low. Sustained rate is one request
// per cycle as long as results are taken; text_stall rises only when the
// queue is full. The final result caused by each request carries last.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 4   // commands held between front and output, at least 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  b64d_pkg::text_t    text,
  output logic               result_valid,
  input  logic               result_stall,
  output b64d_pkg::result_t  result
);

  b64d_pkg::cmd_t          front_cmd;
  b64d_pkg::cmd_t          head_cmd;
  b64d_pkg::fifo_status_t  fifo_status;
  logic                    push;
  logic                    pop;
  logic                    accept;

  // a request is taken whenever the queue has room
  assign text_stall = fifo_status.full;
  assign accept     = text_valid && !text_stall;

  b64d_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .text   (text),
    .push   (push),
    .cmd    (front_cmd)
  );

  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head_cmd),
    .status   (fifo_status)
  );

  // output register decouples the queue from the result stall
  b64d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_cmd),
    .fifo_status  (fifo_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[rtl/b64d_check.sv]
// b64d_check: port-level checks of the base64 decoder, bound to the top level
// depends on b64d_pkg and base64_stream_decoder_assert.svh
`timescale 1ns / 1ps
`include "base64_stream_decoder_assert.svh"

module b64d_check (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input b64d_pkg::result_t  result
);

  // no result shows right after reset
  `B64D_ASSERT_ALWAYS(a_reset_idle, rst |=> !result_valid)

  // a stalled result holds
  `B64D_ASSERT(a_stall_hold, result_valid && result_stall |=> result_valid && $stable(result))

  // end status is always the only and final result of its request
  `B64D_ASSERT(a_end_last, result_valid && result.kind |-> result.last && result.out_byte == 8'd0)

  // data results never carry a status
  `B64D_ASSERT(a_data_status, result_valid && !result.kind |-> !result.status)

endmodule

bind base64_stream_decoder b64d_check u_check (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
